[rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition that must hold always.
`define CHK_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

[rtl/bmb_pkg.sv]
// Package for the banked memory bus: commands, I/O addresses, control struct.
// No dependencies.
package bmb_pkg;
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_TICK  = 3'd2;
  localparam logic [2:0] CMD_BREAK = 3'd3;
  localparam logic [2:0] CMD_EAR   = 3'd4;

  localparam logic [15:0] IO_REMOTE0 = 16'hee00;
  localparam logic [15:0] IO_REMOTE1 = 16'hee20;
  localparam logic [15:0] IO_INVERT  = 16'hee40;
  localparam logic [15:0] IO_SOUND   = 16'hee80;
  localparam logic [15:0] IO_KEYS    = 16'heec0;
  localparam logic [15:0] IO_BREAK   = 16'hef80;
  localparam logic [15:0] IO_BANK    = 16'hefd0;
  localparam logic [15:0] IO_MODE    = 16'hefe0;
  localparam logic [15:0] IO_CHARCOL = 16'he890;
  localparam logic [15:0] IO_BGCOL   = 16'he891;
  localparam logic [15:0] IO_BOARD   = 16'he892;
  localparam logic [15:0] PIA_LAST   = 16'he803;

  typedef struct packed {
    logic clear;   // clearing pass after reset, one RAM entry per cycle
    logic start;   // latch request, begin memory access
    logic finish;  // update registers, load output
  } bmb_cmd_t;
endpackage

[rtl/bmb_ctrl.sv]
// Controller for the memory bus: clearing pass, accept, memory cycle, output handshake.
// Depends on bmb_pkg.
module bmb_ctrl
  import bmb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     clear_done,
  output bmb_cmd_t cmd
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MEM   = 2'd1;
  localparam logic [1:0] S_OUT   = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign cmd.clear  = (state == S_CLEAR);
  assign cmd.start  = in_valid && in_ready;
  assign cmd.finish = (state == S_MEM);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clear_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_MEM;
      S_MEM:   state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  `include "assert_macros.svh"
  `CHK_IMPL(a_mem_then_out, clk, rst, (state != S_MEM) || (state_next == S_OUT), "mem must go to out")
  `CHK_IMPL(a_no_both, clk, rst, !(in_ready && out_valid), "accept while output pending")
  `CHK_IMPL(a_clear_hold, clk, rst, !(cmd.clear && in_ready), "accept during clearing pass")
endmodule

[rtl/bmb_datapath.sv]
// Datapath: RAM, attribute store, I/O registers, key scan and result register.
// Depends on bmb_pkg.
module bmb_datapath
  import bmb_pkg::*;
#(
  parameter int KEY_COLUMNS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  bmb_cmd_t    cmd,
  input  logic [2:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  write_value,
  input  logic [55:0] key_matrix,
  input  logic        ear_level,
  input  logic [7:0]  pia_read_value,
  output logic        clear_done,
  output logic [7:0]  read_value,
  output logic        pia_access,
  output logic        pia_is_write,
  output logic [1:0]  pia_register,
  output logic        nmi_pulse,
  output logic        mic_update,
  output logic        mic_level,
  output logic        remote_update,
  output logic        remote_on,
  output logic [4:0]  sound_level
);
  logic [2:0]  r_cmd;
  logic [15:0] r_addr;
  logic [7:0]  r_data, r_pia;
  logic [55:0] r_keys;
  logic        r_ear;

  logic [7:0] main_ram [65536];
  logic [7:0] colour_attributes [768];
  logic [7:0] ram_q;

  logic [7:0] bank_select, screen_mode_reg, char_colour, background_colour;
  logic [7:0] colour_board_enable, scan_result;
  logic [3:0] scan_column;
  logic       screen_inverted, nmi_enabled, break_latched, tape_in;
  logic [4:0] dac_level;

  // clearing pass: zero RAM, attributes to 7, one entry per cycle
  logic [15:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + 16'd1;
  end
  assign clear_done = (clr_addr == 16'hffff);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_cmd <= command; r_addr <= address; r_data <= write_value;
      r_keys <= key_matrix; r_ear <= ear_level; r_pia <= pia_read_value;
    end
  end

  logic is_io_hi, is_io_lo, is_ram_area, ram_we, attr_we;
  always_comb begin
    is_io_hi = (r_addr[15:9] == IO_REMOTE0[15:9]);
    is_io_lo = (r_addr[15:11] == 5'h1d) && !bank_select[1];
    if (r_addr < 16'hb000) is_ram_area = 1'b1;
    else if (r_addr < 16'he000) is_ram_area = bank_select[0];
    else if (r_addr < 16'hf000) is_ram_area = bank_select[1];
    else is_ram_area = bank_select[2];
    ram_we  = cmd.finish && r_cmd == CMD_WRITE && !is_io_hi && !is_io_lo && is_ram_area;
    attr_we = cmd.finish && r_cmd == CMD_WRITE && !is_io_hi && !is_io_lo &&
              r_addr >= 16'h0100 && r_addr < 16'h0400;
  end

  // sync read issued at the accepting edge, data ready in the memory cycle
  always_ff @(posedge clk) begin
    if (cmd.start) ram_q <= main_ram[address];
    if (cmd.clear) main_ram[clr_addr] <= 8'h00;
    else if (ram_we) main_ram[r_addr] <= r_data;
  end

  logic [9:0] attr_idx;
  assign attr_idx = r_addr[9:0] - 10'h100;
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if (clr_addr < 16'd768) colour_attributes[clr_addr[9:0]] <= 8'd7;
    end else if (attr_we) colour_attributes[attr_idx] <= char_colour;
  end

  function automatic logic [7:0] scan(input logic [3:0] col, input logic [55:0] k);
    logic [7:0] v;
    logic [5:0] base;
    v = 8'hff;
    base = {col, 2'b00};
    if (col < 4'(KEY_COLUMNS))
      for (int r = 0; r < 4; r++) if (k[base + 6'(r)]) v[r] = 1'b0;
    for (int r = 0; r < 4; r++) if (k[52 + r]) v[4 + r] = 1'b0;
    return v;
  endfunction

  logic [7:0] rv;
  logic pa, pw, nm, mu, ml, ru, ro;
  always_comb begin
    rv = 8'h00; pa = 1'b0; pw = 1'b0; nm = 1'b0; mu = 1'b0; ml = 1'b0;
    ru = 1'b0; ro = 1'b0;
    if (r_cmd == CMD_READ) begin
      if (is_io_hi) begin
        unique case (r_addr)
          IO_REMOTE0, IO_REMOTE1: begin ru = 1'b1; ro = r_addr[5]; rv = 8'h01; end
          IO_SOUND: rv = {tape_in, 7'b0};
          IO_KEYS:  rv = scan_result;
          IO_BREAK: rv = {break_latched, 7'b0};
          IO_BANK:  rv = bank_select;
          default:  rv = 8'hff;
        endcase
      end else if (is_io_lo) begin
        if (r_addr <= PIA_LAST) begin pa = 1'b1; rv = r_pia; end
        else if (r_addr == IO_CHARCOL) rv = char_colour;
        else if (r_addr == IO_BGCOL) rv = background_colour;
        else if (r_addr == IO_BOARD) rv = colour_board_enable;
        else rv = 8'hff;
      end else if (is_ram_area) rv = ram_q;
      else rv = 8'hff;
    end else if (r_cmd == CMD_WRITE) begin
      if (is_io_hi) begin
        if (r_addr == IO_SOUND) begin mu = 1'b1; ml = ~r_data[0]; end
      end else if (is_io_lo && r_addr <= PIA_LAST) begin
        pa = 1'b1; pw = 1'b1;
      end
    end else if (r_cmd == CMD_BREAK) nm = nmi_enabled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select <= '0; screen_mode_reg <= '0; screen_inverted <= 1'b0;
      char_colour <= 8'd7; background_colour <= '0; colour_board_enable <= '0;
      scan_column <= '0; scan_result <= 8'hff; nmi_enabled <= 1'b0;
      break_latched <= 1'b0; dac_level <= '0; tape_in <= 1'b0;
      read_value <= '0; pia_access <= 1'b0; pia_is_write <= 1'b0;
      pia_register <= '0; nmi_pulse <= 1'b0; mic_update <= 1'b0; mic_level <= 1'b0;
      remote_update <= 1'b0; remote_on <= 1'b0;
    end else if (cmd.finish) begin
      read_value <= rv; pia_access <= pa; pia_is_write <= pw;
      pia_register <= pa ? r_addr[1:0] : 2'b00;
      nmi_pulse <= nm; mic_update <= mu; mic_level <= ml;
      remote_update <= ru; remote_on <= ro;
      case (r_cmd)
        CMD_READ: if (is_io_hi && r_addr == IO_BREAK) break_latched <= 1'b0;
        CMD_WRITE: begin
          if (is_io_hi) begin
            case (r_addr)
              IO_INVERT: screen_inverted <= r_data[7];
              IO_SOUND:  dac_level <= r_data[5:1];
              IO_KEYS: begin
                scan_column <= r_data[3:0]; nmi_enabled <= r_data[7];
                scan_result <= scan(r_data[3:0], r_keys);
              end
              IO_BANK: bank_select <= r_data;
              IO_MODE: screen_mode_reg <= r_data;
              default: ;
            endcase
          end else if (is_io_lo) begin
            if (r_addr == IO_CHARCOL) char_colour <= r_data;
            else if (r_addr == IO_BGCOL) background_colour <= r_data;
            else if (r_addr == IO_BOARD) colour_board_enable <= r_data;
          end
        end
        CMD_TICK:  scan_result <= scan(scan_column, r_keys);
        CMD_BREAK: break_latched <= 1'b1;
        CMD_EAR:   tape_in <= r_ear;
        default: ;
      endcase
    end
  end

  assign sound_level = dac_level;

  `include "assert_macros.svh"
  `CHK_IMPL(a_pia_reg, clk, rst, pia_access || pia_register == 2'b00, "pia reg without access")
  `CHK_IMPL(a_pia_w, clk, rst, !pia_is_write || pia_access, "pia write without access")
  `CHK_IMPL(a_remote, clk, rst, !remote_on || remote_update, "remote on without update")
endmodule

[rtl/banked_memory_bus_with_io_core.sv]
// Banked memory bus top level; depends on bmb_pkg, bmb_ctrl and bmb_datapath.
// Flow: the request is registered at the accepting edge, then the memory cycle (S_MEM)
// loads the output register and m_tvalid rises in S_OUT; a new request is accepted
// only after the result is taken, since s_tready is high in S_IDLE alone.
// Reset (rst, synchronous): I/O registers to defaults, then a clearing pass zeroes
// all 65536 RAM entries and sets attributes to 7 while s_tready stays low.
module banked_memory_bus_with_io_core
  import bmb_pkg::*;
#(
  parameter int KEY_COLUMNS = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[2:0], address[18:3], write_value[26:19], key_matrix[82:27],
  // ear_level[83], pia_read_value[91:84], zero fill
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // read_value[7:0], pia_access[8], pia_is_write[9], pia_register[11:10],
  // nmi_pulse[12], mic_update[13], mic_level[14], remote_update[15],
  // remote_on[16], sound_level[21:17], zero fill
  output logic [23:0]  m_tdata
);
  bmb_cmd_t cmd;
  logic     clear_done;

  bmb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .clear_done(clear_done), .cmd(cmd)
  );

  bmb_datapath #(.KEY_COLUMNS(KEY_COLUMNS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .command(s_tdata[2:0]), .address(s_tdata[18:3]), .write_value(s_tdata[26:19]),
    .key_matrix(s_tdata[82:27]), .ear_level(s_tdata[83]), .pia_read_value(s_tdata[91:84]),
    .clear_done(clear_done),
    .read_value(m_tdata[7:0]), .pia_access(m_tdata[8]), .pia_is_write(m_tdata[9]),
    .pia_register(m_tdata[11:10]), .nmi_pulse(m_tdata[12]), .mic_update(m_tdata[13]),
    .mic_level(m_tdata[14]), .remote_update(m_tdata[15]), .remote_on(m_tdata[16]),
    .sound_level(m_tdata[21:17])
  );
  assign m_tdata[23:22] = 2'b00;
endmodule

[bench/testbench.sv]
// Testbench for banked_memory_bus_with_io_core: random and directed bus requests,
// checked against a behavioural model of the memory map. Depends on bmb_pkg.
`timescale 1ns / 100ps

module testbench;
  import bmb_pkg::*;

  typedef struct packed {
    logic [4:0] sound_level;
    logic       remote_on;
    logic       remote_update;
    logic       mic_level;
    logic       mic_update;
    logic       nmi_pulse;
    logic [1:0] pia_register;
    logic       pia_is_write;
    logic       pia_access;
    logic [7:0] read_value;
  } bus_result_t;

  class bus_scoreboard;
    logic [7:0]  ram [65536];
    logic [7:0]  attr [768];
    logic [7:0]  bank, mode, char_col, bg_col, board, scan_res;
    logic [3:0]  scan_col;
    logic        inverted, nmi_en, brk, tape;
    logic [4:0]  dac;
    bus_result_t pending [$];
    int          errors;

    function new();
      foreach (ram[i]) ram[i] = 8'h00;
      foreach (attr[i]) attr[i] = 8'h07;
      bank = 0; mode = 0; char_col = 8'h07; bg_col = 0; board = 0;
      scan_res = 8'hff; scan_col = 0; inverted = 0; nmi_en = 0; brk = 0;
      tape = 0; dac = 0; errors = 0;
    endfunction

    function void rescan(logic [55:0] keys);
      logic [7:0] v;
      v = 8'hff;
      if (scan_col < 13)
        for (int r = 0; r < 4; r++) if (keys[4 * scan_col + r]) v[r] = 1'b0;
      for (int r = 0; r < 4; r++) if (keys[52 + r]) v[4 + r] = 1'b0;
      scan_res = v;
    endfunction

    function logic [7:0] mem_rd(logic [15:0] a);
      if (a < 16'hb000) return ram[a];
      if (a < 16'he000) return bank[0] ? ram[a] : 8'hff;
      if (a < 16'hf000) return bank[1] ? ram[a] : 8'hff;
      return bank[2] ? ram[a] : 8'hff;
    endfunction

    function void note_request(logic [95:0] d);
      logic [2:0]  cmd;
      logic [15:0] a;
      logic [7:0]  wv;
      logic [55:0] keys;
      bus_result_t r;
      logic        is_ram;
      cmd = d[2:0]; a = d[18:3]; wv = d[26:19]; keys = d[82:27];
      r = '0;
      if (cmd == CMD_READ) begin
        if (a[15:9] == IO_REMOTE0[15:9]) begin
          case (a)
            IO_REMOTE0, IO_REMOTE1: begin
              r.remote_update = 1; r.remote_on = a[5]; r.read_value = 8'h01;
            end
            IO_SOUND: r.read_value = tape ? 8'h80 : 8'h00;
            IO_KEYS:  r.read_value = scan_res;
            IO_BREAK: begin r.read_value = brk ? 8'h80 : 8'h00; brk = 0; end
            IO_BANK:  r.read_value = bank;
            default:  r.read_value = 8'hff;
          endcase
        end else if (a[15:11] == 5'b11101 && !bank[1]) begin
          if (a <= PIA_LAST) begin
            r.pia_access = 1; r.pia_register = a[1:0]; r.read_value = d[91:84];
          end else if (a == IO_CHARCOL) r.read_value = char_col;
          else if (a == IO_BGCOL) r.read_value = bg_col;
          else if (a == IO_BOARD) r.read_value = board;
          else r.read_value = 8'hff;
        end else r.read_value = mem_rd(a);
      end else if (cmd == CMD_WRITE) begin
        if (a[15:9] == IO_REMOTE0[15:9]) begin
          case (a)
            IO_INVERT: inverted = wv[7];
            IO_SOUND: begin dac = wv[5:1]; r.mic_update = 1; r.mic_level = ~wv[0]; end
            IO_KEYS: begin scan_col = wv[3:0]; nmi_en = wv[7]; rescan(keys); end
            IO_BANK: bank = wv;
            IO_MODE: mode = wv;
            default: ;
          endcase
        end else if (a[15:11] == 5'b11101 && !bank[1]) begin
          if (a <= PIA_LAST) begin
            r.pia_access = 1; r.pia_is_write = 1; r.pia_register = a[1:0];
          end else if (a == IO_CHARCOL) char_col = wv;
          else if (a == IO_BGCOL) bg_col = wv;
          else if (a == IO_BOARD) board = wv;
        end else begin
          if (a >= 16'h0100 && a < 16'h0400) attr[a - 16'h0100] = char_col;
          if (a < 16'hb000) is_ram = 1;
          else if (a < 16'he000) is_ram = bank[0];
          else if (a < 16'hf000) is_ram = bank[1];
          else is_ram = bank[2];
          if (is_ram) ram[a] = wv;
        end
      end else if (cmd == CMD_TICK) rescan(keys);
      else if (cmd == CMD_BREAK) begin r.nmi_pulse = nmi_en; brk = 1; end
      else if (cmd == CMD_EAR) tape = d[83];
      r.sound_level = dac;
      pending.push_back(r);
    endfunction

    function void check_result(logic [23:0] got);
      bus_result_t e, g;
      g = got[21:0];
      if (got[23:22] != 0) begin
        $display("%0t: fill bits expected 0 actual %h", $time, got[23:22]);
        errors++;
      end
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g.read_value != e.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, e.read_value, g.read_value);
        errors++;
      end
      if ({g.pia_access, g.pia_is_write, g.pia_register}
          != {e.pia_access, e.pia_is_write, e.pia_register}) begin
        $display("%0t: pia acc/wr/reg expected %b%b%0d actual %b%b%0d", $time,
                 e.pia_access, e.pia_is_write, e.pia_register,
                 g.pia_access, g.pia_is_write, g.pia_register);
        errors++;
      end
      if (g.nmi_pulse != e.nmi_pulse) begin
        $display("%0t: nmi_pulse expected %b actual %b", $time, e.nmi_pulse, g.nmi_pulse);
        errors++;
      end
      if ({g.mic_update, g.mic_level} != {e.mic_update, e.mic_level}) begin
        $display("%0t: mic upd/lvl expected %b%b actual %b%b", $time,
                 e.mic_update, e.mic_level, g.mic_update, g.mic_level);
        errors++;
      end
      if ({g.remote_update, g.remote_on} != {e.remote_update, e.remote_on}) begin
        $display("%0t: remote upd/on expected %b%b actual %b%b", $time,
                 e.remote_update, e.remote_on, g.remote_update, g.remote_on);
        errors++;
      end
      if (g.sound_level != e.sound_level) begin
        $display("%0t: sound_level expected %0d actual %0d", $time,
                 e.sound_level, g.sound_level);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [95:0] s_tdata;
  logic [23:0] m_tdata;

  bus_scoreboard board_model;
  bit  quiet_phase;
  bit  hold_off;
  int  n_sent, n_got;

  banked_memory_bus_with_io_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // covers the RAM clearing pass after reset plus the worst-case stalls
  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

  // one request; random idle burst before it unless in the quiet phase
  task automatic send_request(input logic [2:0] cmd, input logic [15:0] a,
                              input logic [7:0] wv);
    logic [55:0] keys;
    keys = {$urandom, $urandom};
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {4'b0, 8'($urandom), 1'($urandom), keys, wv, a, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board_model.note_request(s_tdata);
    n_sent++;
  endtask

  task automatic random_request();
    logic [15:0] a;
    int          pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: a = 16'hee00 | 16'($urandom_range(0, 7) << 5) | 16'($urandom_range(0, 1) << 8);
      1: a = 16'he800 + 16'($urandom_range(0, 3));
      2: a = 16'he890 + 16'($urandom_range(0, 3));
      3: a = 16'h0100 + 16'($urandom_range(0, 16));
      4: a = 16'($urandom_range(0, 31)) | 16'hb000;
      5: a = 16'($urandom_range(0, 31)) | 16'he000;
      6: a = 16'($urandom_range(0, 31)) | 16'hf000;
      7: a = 16'(16'hea00 + $urandom_range(0, 255));
      default: a = 16'($urandom);
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 9) send_request(CMD_READ, a, 8'($urandom));
    else if (pick < 17)
      send_request(CMD_WRITE, (a == IO_BANK && $urandom_range(0, 1)) ? a : a,
                   8'($urandom));
    else send_request(3'($urandom_range(2, 7)), a, 8'($urandom));
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = '0; m_tready = 0;
    quiet_phase = 0; hold_off = 0; n_sent = 0; n_got = 0;
    board_model = new();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: every command, field extremes, I/O registers, bank bits
    send_request(CMD_READ, 16'h0000, 8'h00);
    send_request(CMD_WRITE, 16'hffff, 8'hff);
    send_request(CMD_READ, 16'hffff, 8'h00);
    send_request(CMD_WRITE, 16'h0100, 8'hff);
    send_request(CMD_WRITE, IO_CHARCOL, 8'h5a);
    send_request(CMD_READ, IO_CHARCOL, 8'h00);
    send_request(CMD_WRITE, IO_KEYS, 8'h8f);
    send_request(CMD_READ, IO_KEYS, 8'h00);
    send_request(CMD_BREAK, 16'h0000, 8'h00);
    send_request(CMD_READ, IO_BREAK, 8'h00);
    send_request(CMD_READ, IO_BREAK, 8'h00);
    send_request(CMD_EAR, 16'h0000, 8'h00);
    send_request(CMD_READ, IO_SOUND, 8'h00);
    send_request(CMD_WRITE, IO_SOUND, 8'hff);
    send_request(CMD_WRITE, IO_SOUND, 8'h00);
    send_request(CMD_READ, IO_REMOTE1, 8'h00);
    send_request(CMD_WRITE, 16'he803, 8'h12);
    send_request(CMD_READ, 16'he800, 8'h00);
    send_request(CMD_WRITE, IO_BANK, 8'h07);
    send_request(CMD_WRITE, 16'he801, 8'h33);
    send_request(CMD_READ, 16'he801, 8'h00);
    send_request(CMD_WRITE, 16'hb000, 8'h44);
    send_request(CMD_READ, 16'hb000, 8'h00);
    send_request(CMD_WRITE, IO_BANK, 8'h00);
    send_request(CMD_TICK, 16'h0000, 8'h00);
    for (int i = 0; i < 1700; i++) begin
      if (i == 1500) quiet_phase = 1;
      if (i % 150 == 0) send_request(CMD_WRITE, IO_BANK, 8'($urandom_range(0, 7)));
      random_request();
    end
    s_tvalid <= 0;
    while (board_model.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d requests and %0d results: RAM, ROM banks, I/O, PIA, keys, break",
             n_sent, n_got);
    if (board_model.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        board_model.check_result(m_tdata);
        n_got++;
      end
      if (n_sent == 300 && !hold_off) begin
        hold_off = 1;
        stall = 200;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 9);
        m_tready <= 0;
      end else m_tready <= 1;
    end
  end
endmodule
